@@ hw/rtl/pid_keyed_status_slot_table_assert.svh @@
// Assertion macros shared by the PID slot table RTL.
`ifndef PID_KEYED_STATUS_SLOT_TABLE_ASSERT_SVH
`define PID_KEYED_STATUS_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and switched off while in reset.
`define PKST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off while in reset.
`define PKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pkst_pkg.sv @@
// Package: widths, codes, types and constants shared by the PID slot table.
`default_nettype none

package pkst_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned KeyW = 22;
  localparam int unsigned PayW = 64;
  localparam int unsigned IdxW = 6;

  localparam int unsigned SlotsDefault       = 64;
  localparam int unsigned PayloadBitsDefault = 64;
  localparam int unsigned KeyBitsDefault     = 22;

  // The key is reduced modulo the slot count one byte per cycle.
  localparam int unsigned DigitW    = 8;
  localparam int unsigned NumDigits = (KeyW + DigitW - 1) / DigitW;
  localparam int unsigned DigCntW   = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned QDepth = 2;

  localparam logic [CmdW-1:0] CMD_SET    = 3'd0;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 3'd2;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 3'd3;
  localparam logic [CmdW-1:0] CMD_DUMP   = 3'd4;

  typedef enum logic [2:0] {
    OP_SET,
    OP_CLEAR,
    OP_READ,
    OP_LOOKUP,
    OP_DUMP,
    OP_MISS
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    logic [IdxW-1:0] start;
  } desc_t;

  typedef struct packed {
    logic            hit;
    logic            full_res;
    logic [IdxW-1:0] slot_index;
    logic [KeyW-1:0] owner_pid;
    logic [PayW-1:0] data_out;
    logic            last;
  } res_t;

  localparam res_t ResMiss = '{hit: 1'b0, full_res: 1'b0, slot_index: '0,
                               owner_pid: '0, data_out: '0, last: 1'b1};
  localparam res_t ResFull = '{hit: 1'b0, full_res: 1'b1, slot_index: '0,
                               owner_pid: '0, data_out: '0, last: 1'b1};

endpackage

`default_nettype wire

@@ hw/rtl/pkst_in_if.sv @@
// Interface: command channel into the PID slot table.
`default_nettype none

interface pkst_in_if import pkst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [KeyW-1:0] key_pid;
  logic [PayW-1:0] payload;

  modport source (output valid, output cmd, output key_pid, output payload, input ready);
  modport sink (input valid, input cmd, input key_pid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pkst_out_if.sv @@
// Interface: result channel out of the PID slot table.
`default_nettype none

interface pkst_out_if import pkst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            hit;
  logic            full_res;
  logic [IdxW-1:0] slot_index;
  logic [KeyW-1:0] owner_pid;
  logic [PayW-1:0] data_out;
  logic            last;

  modport source (output valid, output hit, output full_res, output slot_index,
                  output owner_pid, output data_out, output last, input ready);
  modport sink (input valid, input hit, input full_res, input slot_index,
                input owner_pid, input data_out, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pkst_front.sv @@
// Front part: accepts commands, classifies them and reduces the key to its home slot.
`default_nettype none

module pkst_front import pkst_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDefault,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDefault,
  parameter int unsigned KEY_BITS     = KeyBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pkst_in_if.sink req_i,
  output logic  desc_valid_o,
  input  logic  desc_ready_i,
  output desc_t desc_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned OwnW  = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;
  localparam int unsigned ShW   = NumDigits * DigitW;
  localparam logic [SlotW:0] SlotsC = (SlotW + 1)'(SLOTS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e             st_q, st_d;
  op_e                 op_q, op_c;
  logic [KeyW-1:0]     key_q, key_m;
  logic [PayW-1:0]     pay_q, pay_m;
  logic [ShW-1:0]      sh_q;
  logic [SlotW-1:0]    rem_q, rem_nx;
  logic [SlotW:0]      rem_w;
  logic [DigCntW-1:0]  dig_q;
  logic                last_dig;
  logic                accept;

  assign key_m  = KeyW'(req_i.key_pid[OwnW-1:0]);
  assign pay_m  = PayW'(req_i.payload[PAYLOAD_BITS-1:0]);
  assign accept = req_i.valid && req_i.ready;

  always_comb begin
    unique case (req_i.cmd)
      CMD_SET:    op_c = OP_SET;
      CMD_CLEAR:  op_c = OP_CLEAR;
      CMD_READ:   op_c = OP_READ;
      CMD_LOOKUP: op_c = OP_LOOKUP;
      CMD_DUMP:   op_c = OP_DUMP;
      default:    op_c = OP_MISS;
    endcase
    // A zero key means an empty slot, so it can neither claim nor be found.
    if (key_m == '0 && op_c != OP_DUMP) begin
      op_c = OP_MISS;
    end
  end

  // Restoring remainder, one key bit per step, one byte per cycle, MSB first.
  always_comb begin
    rem_w = {1'b0, rem_q};
    for (int b = 0; b < DigitW; b++) begin
      rem_w = {rem_w[SlotW-1:0], sh_q[ShW-1-b]};
      if (rem_w >= SlotsC) begin
        rem_w = rem_w - SlotsC;
      end
    end
    rem_nx = rem_w[SlotW-1:0];
  end

  assign last_dig      = (dig_q == DigCntW'(NumDigits - 1));
  assign req_i.ready   = (st_q == F_IDLE);
  assign desc_valid_o  = (st_q == F_PUSH) || ((st_q == F_MOD) && last_dig);
  assign desc_o.op     = op_q;
  assign desc_o.key    = key_q;
  assign desc_o.pay    = pay_q;
  assign desc_o.start  = IdxW'((st_q == F_MOD) ? rem_nx : rem_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      F_IDLE: begin
        if (req_i.valid) begin
          st_d = F_MOD;
        end
      end
      F_MOD: begin
        if (last_dig) begin
          st_d = desc_ready_i ? F_IDLE : F_PUSH;
        end
      end
      F_PUSH: begin
        if (desc_ready_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= F_IDLE;
      dig_q <= '0;
      rem_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == F_IDLE) begin
        dig_q <= '0;
        rem_q <= '0;
      end else if (st_q == F_MOD) begin
        dig_q <= dig_q + 1'b1;
        rem_q <= rem_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_c;
      key_q <= key_m;
      pay_q <= pay_m;
      sh_q  <= ShW'(key_m);
    end else if (st_q == F_MOD) begin
      sh_q <= sh_q << DigitW;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pkst_fifo.sv @@
// Short command queue between the front and back parts.
`default_nettype none

module pkst_fifo import pkst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  desc_t push_desc_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output desc_t pop_desc_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  desc_t           mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pkst_back.sv @@
// Back part: probes the slot table, applies commands and drives the result register.
`default_nettype none

module pkst_back import pkst_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDefault,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDefault,
  parameter int unsigned KEY_BITS     = KeyBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  desc_valid_i,
  output logic  desc_ready_o,
  input  desc_t desc_i,
  pkst_out_if.source rsp_o,
  output logic  valid_orphan_o
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned OwnW  = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SCAN = 6'b000010,
    B_CMP  = 6'b000100,
    B_DUMP = 6'b001000,
    B_DRD  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_e;

  bstate_e                 st_q, st_d, ret_q, ret_d;
  desc_t                   cur_q, cur_d;
  res_t                    res_q, res_d, out_q;
  logic                    out_valid_q;
  logic [SlotW-1:0]        ptr_q, ptr_d, ptr_inc;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [SLOTS-1:0]        owned_q, valid_q, above;
  logic [OwnW-1:0]         owner_mem_q [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem_q [SLOTS];
  logic [OwnW-1:0]         owner_rd_q, key_own;
  logic [PAYLOAD_BITS-1:0] pay_rd_q;
  logic                    rd_en, claim, advance, out_free, out_load, match, last_valid;

  assign key_own        = cur_q.key[OwnW-1:0];
  assign match          = (owner_rd_q == key_own);
  assign ptr_inc        = (ptr_q == SlotW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;
  assign out_free       = !out_valid_q || rsp_o.ready;
  assign valid_orphan_o = |(valid_q & ~owned_q);

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (SlotW'(j) > ptr_q);
    end
  end

  // A dumped slot is the last one when no valid slot lies above it.
  assign last_valid = ~|(valid_q & above);

  always_comb begin
    st_d         = st_q;
    ret_d        = ret_q;
    cur_d        = cur_q;
    res_d        = res_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    desc_ready_o = 1'b0;
    rd_en        = 1'b0;
    claim        = 1'b0;
    advance      = 1'b0;
    out_load     = 1'b0;
    unique case (st_q)
      B_IDLE: begin
        desc_ready_o = 1'b1;
        if (desc_valid_i) begin
          cur_d = desc_i;
          cnt_d = '0;
          ret_d = B_IDLE;
          ptr_d = (desc_i.op == OP_DUMP) ? '0 : desc_i.start[SlotW-1:0];
          if (desc_i.op == OP_MISS || (desc_i.op == OP_DUMP && valid_q == '0)) begin
            res_d = ResMiss;
            st_d  = B_OUT;
          end else if (desc_i.op == OP_DUMP) begin
            st_d = B_DUMP;
          end else begin
            st_d = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (cnt_q == CntW'(SLOTS)) begin
          res_d = (cur_q.op == OP_LOOKUP) ? ResMiss : ResFull;
          st_d  = B_OUT;
        end else if (!owned_q[ptr_q]) begin
          // An empty slot ends a lookup and is taken by a claim.
          if (cur_q.op == OP_LOOKUP) begin
            res_d = ResMiss;
            st_d  = B_OUT;
          end else begin
            claim = 1'b1;
          end
        end else begin
          rd_en = 1'b1;
          st_d  = B_CMP;
        end
      end
      B_CMP: begin
        if (cur_q.op == OP_LOOKUP) begin
          if (match && valid_q[ptr_q]) begin
            res_d = '{hit: 1'b1, full_res: 1'b0, slot_index: IdxW'(ptr_q),
                      owner_pid: cur_q.key, data_out: PayW'(pay_rd_q), last: 1'b1};
            st_d  = B_OUT;
          end else begin
            advance = 1'b1;
          end
        end else if (match) begin
          claim = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      B_DUMP: begin
        if (valid_q[ptr_q]) begin
          rd_en = 1'b1;
          st_d  = B_DRD;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      B_DRD: begin
        res_d = '{hit: 1'b1, full_res: 1'b0, slot_index: IdxW'(ptr_q),
                  owner_pid: KeyW'(owner_rd_q), data_out: PayW'(pay_rd_q),
                  last: last_valid};
        ret_d = last_valid ? B_IDLE : B_DUMP;
        ptr_d = ptr_inc;
        st_d  = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          st_d     = ret_q;
        end
      end
      default: st_d = B_IDLE;
    endcase

    if (advance) begin
      ptr_d = ptr_inc;
      cnt_d = cnt_q + 1'b1;
      st_d  = B_SCAN;
    end

    if (claim) begin
      res_d = '{hit: 1'b1, full_res: 1'b0, slot_index: IdxW'(ptr_q),
                owner_pid: cur_q.key, data_out: '0, last: 1'b1};
      if (cur_q.op == OP_SET) begin
        res_d.data_out = cur_q.pay;
      end else if (cur_q.op == OP_READ) begin
        // A freshly taken slot is never valid, so its stale read data is masked.
        res_d.hit      = valid_q[ptr_q];
        res_d.data_out = valid_q[ptr_q] ? PayW'(pay_rd_q) : '0;
      end
      st_d = B_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      ret_q       <= B_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      owned_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (claim) begin
        owned_q[ptr_q] <= 1'b1;
        if (cur_q.op == OP_SET) begin
          valid_q[ptr_q] <= 1'b1;
        end else if (cur_q.op == OP_CLEAR) begin
          valid_q[ptr_q] <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Slot stores: owners are read only once written, payloads used only while valid.
  always_ff @(posedge clk_i) begin
    if (claim) begin
      owner_mem_q[ptr_q] <= key_own;
    end
    if (claim && cur_q.op == OP_SET) begin
      pay_mem_q[ptr_q] <= cur_q.pay[PAYLOAD_BITS-1:0];
    end
    if (rd_en) begin
      owner_rd_q <= owner_mem_q[ptr_q];
      pay_rd_q   <= pay_mem_q[ptr_q];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_q.hit;
  assign rsp_o.full_res   = out_q.full_res;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.owner_pid  = out_q.owner_pid;
  assign rsp_o.data_out   = out_q.data_out;
  assign rsp_o.last       = out_q.last;

endmodule

`default_nettype wire

@@ hw/rtl/pid_keyed_status_slot_table.sv @@
// Top level of the PID keyed status slot table: front part, command queue, back part.
//
//   Port     Dir   Handshake     Beat contents
//   req_i    in    valid/ready   cmd, key_pid, payload
//   rsp_o    out   valid/ready   hit, full_res, slot_index, owner_pid, data_out, last
//
// The front takes one beat at a time: after the accept it works out the home slot
// a byte of the key at a time, and takes the next beat once the descriptor is queued.
// In the back, set, clear, read and lookup probe from the home slot, with one read of
// the slot store per occupied slot probed, until a match, an empty slot or all slots
// were probed in vain. Dump walks up from slot 0 and reads each valid slot up to the
// last valid one. Reset clears the owned and valid flags at once; the stores need no
// clearing. A held result stalls only the back; the two-entry queue keeps the front
// going until it fills.
`default_nettype none
`include "pid_keyed_status_slot_table_assert.svh"

module pid_keyed_status_slot_table import pkst_pkg::*; #(
  parameter int unsigned SLOTS        = SlotsDefault,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDefault,
  parameter int unsigned KEY_BITS     = KeyBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pkst_in_if.sink     req_i,
  pkst_out_if.source  rsp_o
);

  logic  fr_valid, fr_ready, bk_valid, bk_ready, valid_orphan;
  desc_t fr_desc, bk_desc;

  pkst_front #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .KEY_BITS     (KEY_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .desc_valid_o (fr_valid),
    .desc_ready_i (fr_ready),
    .desc_o       (fr_desc)
  );

  pkst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_desc_i  (fr_desc),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_desc_o   (bk_desc)
  );

  pkst_back #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .KEY_BITS     (KEY_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (bk_valid),
    .desc_ready_o   (bk_ready),
    .desc_i         (bk_desc),
    .rsp_o          (rsp_o),
    .valid_orphan_o (valid_orphan)
  );

  // The front reduces one key at a time, so it is busy right after an accepted beat.
  `PKST_ASSERT_NEXT(a_front_busy, req_i.valid && req_i.ready, !req_i.ready, "front took two beats in a row")

  // A slot can only hold a valid payload once it has an owner.
  `PKST_ASSERT_NOW(a_valid_owned, 1'b1, !valid_orphan, "valid slot without an owner")

  // Only a dump gives more than one result, and each of those is a hit.
  `PKST_ASSERT_NOW(a_partial_dump, rsp_o.valid && !rsp_o.last, rsp_o.hit && !rsp_o.full_res, "non-final result that is not a dumped slot")

  // A full table result is a single zeroed miss.
  `PKST_ASSERT_NOW(a_full_final, rsp_o.valid && rsp_o.full_res, !rsp_o.hit && rsp_o.last && rsp_o.slot_index == '0, "malformed full table result")

endmodule

`default_nettype wire
